### sv/meter_frame_receiver_decoder_top_assert.svh
// Assertion macros for the meter frame receiver checker.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef METER_FRAME_RECEIVER_DECODER_TOP_ASSERT_SVH
`define METER_FRAME_RECEIVER_DECODER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define MFRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MFRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always on
`define MFRD_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mfrd_pkg.sv
// Shared types, constants and helpers of the meter frame receiver.
// No dependencies.
`default_nettype none
package mfrd_pkg;

    localparam logic [7:0] START_BYTE   = 8'h68;
    localparam logic [7:0] DATA_OFFSET  = 8'h33;
    localparam logic [7:0] READ_REPLY   = 8'h81;
    localparam logic [8:0] FRAME_EXTRA  = 9'd12;
    localparam logic [7:0] MIN_READ_LEN = 8'd6;
    localparam logic [8:0] HDR_LAST_POS = 9'd7;
    localparam logic [8:0] DATA_POS     = 9'd10;
    localparam logic [8:0] DATA_KEEP    = 9'd6;

    localparam int ADDR_W = 48;
    localparam int ID_W   = 16;
    localparam int CFG_W  = 48;
    localparam int READ_W = 28;

    localparam logic [ID_W-1:0] READING_ID_RESET = 16'h1010;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic REG_METER_ADDR = 1'b0;
    localparam logic REG_READING_ID = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_CONTROL,
        PH_LENGTH,
        PH_DATA,
        PH_CSUM,
        PH_END
    } t_phase;

    typedef enum logic [1:0] {
        ST_READING  = 2'd0,
        ST_OTHER    = 2'd1,
        ST_ADDR_ERR = 2'd2,
        ST_CSUM_ERR = 2'd3
    } t_status;

    // classified frame, raw reading bytes 2..5 of data, byte 2 lowest
    typedef struct packed {
        t_status     status;
        logic [7:0]  control;
        logic [8:0]  frame_len;
        logic [31:0] reading_raw;
    } t_rec;

    // one BCD byte to binary, nibbles above nine kept as weighted
    function automatic logic [7:0] bcd_byte(input logic [7:0] b);
        logic [7:0] hi;
        hi = 8'(b[7:4]) * 8'd10;
        return hi + {4'd0, b[3:0]};
    endfunction

endpackage
`default_nettype wire

### sv/meter_frame_receiver_decoder_top.sv
// Meter reply frame receiver and decoder, top level.
// Instantiates mfrd_front, mfrd_queue, mfrd_back. Depends on mfrd_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | i_valid / o_ready  | i_kind, i_rx_byte
//   out     | o_valid / i_ready  | o_status, o_control_code, o_frame_length,
//           |                    | o_reading_hundredths
//   cfg     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One byte or gap per cycle while o_ready is high; the parser steps once per
// accepted request. The edge that takes a frame's last byte writes its result
// into the queue; it then passes through the decode stage and output register.
// Synchronous active-low reset; config registers reset to address 0, id 0x1010.
// o_ready drops only while the frame queue is full.
`default_nettype none
module meter_frame_receiver_decoder_top #(
    parameter int QUEUE_DEPTH = mfrd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_kind,
    input  wire logic [7:0]                   i_rx_byte,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [1:0]                        o_status,
    output logic [7:0]                        o_control_code,
    output logic [8:0]                        o_frame_length,
    output logic [mfrd_pkg::READ_W-1:0]       o_reading_hundredths,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [mfrd_pkg::CFG_W-1:0]   i_cfg_data
);
    import mfrd_pkg::*;

    logic accept, push, full, q_valid, q_pop;
    t_rec push_rec, q_rec;

    assign o_ready = !full;
    assign accept  = i_valid && o_ready;

    mfrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    mfrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rec   (q_rec)
    );

    mfrd_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_valid            (q_valid),
        .i_q_rec              (q_rec),
        .o_q_pop              (q_pop),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_status             (o_status),
        .o_control_code       (o_control_code),
        .o_frame_length       (o_frame_length),
        .o_reading_hundredths (o_reading_hundredths)
    );

endmodule
`default_nettype wire

### sv/mfrd_front.sv
// Front end: byte parser, address/checksum checks, frame classification.
// Holds the configuration registers. Depends on mfrd_pkg.
`default_nettype none
module mfrd_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic                      i_kind,
    input  wire logic [7:0]                i_rx_byte,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [mfrd_pkg::CFG_W-1:0] i_cfg_data,
    output logic                           o_push,
    output mfrd_pkg::t_rec                 o_rec
);
    import mfrd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [8:0]        r_pos, n_pos;
    logic [7:0]        r_sum, n_sum;
    logic              r_addr_ok, n_addr_ok;
    logic [7:0]        r_ctrl, n_ctrl;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_data [6];
    logic [7:0]        n_data [6];
    logic              r_csum_ok, n_csum_ok;
    logic [ADDR_W-1:0] r_meter_addr;
    logic [ID_W-1:0]   r_reading_id;

    logic [7:0] addr_byte;
    logic [8:0] data_off;
    logic       read_ok;
    logic [7:0] id_lo, id_hi;

    always_comb begin
        case (r_pos[2:0])
            3'd1:    addr_byte = r_meter_addr[7:0];
            3'd2:    addr_byte = r_meter_addr[15:8];
            3'd3:    addr_byte = r_meter_addr[23:16];
            3'd4:    addr_byte = r_meter_addr[31:24];
            3'd5:    addr_byte = r_meter_addr[39:32];
            3'd6:    addr_byte = r_meter_addr[47:40];
            default: addr_byte = 8'd0;
        endcase
    end

    assign data_off = r_pos - DATA_POS;
    assign id_lo    = r_data[0] - DATA_OFFSET;
    assign id_hi    = r_data[1] - DATA_OFFSET;
    assign read_ok  = (r_ctrl == READ_REPLY) && (r_len >= MIN_READ_LEN)
                   && (id_lo == r_reading_id[7:0]) && (id_hi == r_reading_id[15:8]);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_addr_ok = r_addr_ok;
        n_ctrl    = r_ctrl;
        n_len     = r_len;
        n_data    = r_data;
        n_csum_ok = r_csum_ok;
        o_push    = 1'b0;
        o_rec     = '{status: ST_ADDR_ERR, control: 8'd0, frame_len: 9'd0,
                      reading_raw: 32'd0};
        if (i_accept) begin
            if (i_kind) begin
                n_phase = PH_HUNT;
                n_pos   = 9'd0;
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_rx_byte == START_BYTE) begin
                            n_phase   = PH_HEADER;
                            n_pos     = 9'd1;
                            n_sum     = i_rx_byte;
                            n_addr_ok = 1'b1;
                            n_ctrl    = 8'd0;
                            n_len     = 8'd0;
                            n_data    = '{default: 8'd0};
                            n_csum_ok = 1'b0;
                        end
                    end
                    PH_HEADER: begin
                        n_sum = r_sum + i_rx_byte;
                        if (r_pos < HDR_LAST_POS) begin
                            if (i_rx_byte != addr_byte) begin
                                n_addr_ok = 1'b0;
                            end
                            n_pos = r_pos + 9'd1;
                        end else if (!r_addr_ok || i_rx_byte != START_BYTE) begin
                            n_phase = PH_HUNT;
                            n_pos   = 9'd0;
                            o_push  = 1'b1;
                        end else begin
                            n_phase = PH_CONTROL;
                            n_pos   = r_pos + 9'd1;
                        end
                    end
                    PH_CONTROL: begin
                        n_sum   = r_sum + i_rx_byte;
                        n_ctrl  = i_rx_byte;
                        n_phase = PH_LENGTH;
                        n_pos   = r_pos + 9'd1;
                    end
                    PH_LENGTH: begin
                        n_sum   = r_sum + i_rx_byte;
                        n_len   = i_rx_byte;
                        n_phase = (i_rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
                        n_pos   = DATA_POS;
                    end
                    PH_DATA: begin
                        n_sum = r_sum + i_rx_byte;
                        if (data_off < DATA_KEEP) begin
                            n_data[data_off[2:0]] = i_rx_byte;
                        end
                        n_pos = r_pos + 9'd1;
                        if ({1'b0, r_pos} + 10'd1 >= {1'b0, DATA_POS} + {2'd0, r_len}) begin
                            n_phase = PH_CSUM;
                        end
                    end
                    PH_CSUM: begin
                        n_csum_ok = (i_rx_byte == r_sum);
                        n_sum     = r_sum + i_rx_byte;
                        n_phase   = PH_END;
                        n_pos     = r_pos + 9'd1;
                    end
                    PH_END: begin
                        o_push = 1'b1;
                        o_rec.status      = !r_csum_ok ? ST_CSUM_ERR
                                          : (read_ok ? ST_READING : ST_OTHER);
                        o_rec.control     = r_ctrl;
                        o_rec.frame_len   = {1'b0, r_len} + FRAME_EXTRA;
                        o_rec.reading_raw = {r_data[5], r_data[4], r_data[3], r_data[2]};
                        n_phase = PH_HUNT;
                        n_pos   = 9'd0;
                    end
                    default: begin
                        n_phase = PH_HUNT;
                        n_pos   = 9'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_pos        <= 9'd0;
            r_meter_addr <= '0;
            r_reading_id <= READING_ID_RESET;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_METER_ADDR: r_meter_addr <= i_cfg_data[ADDR_W-1:0];
                    REG_READING_ID: r_reading_id <= i_cfg_data[ID_W-1:0];
                    default:        r_reading_id <= r_reading_id;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_addr_ok <= n_addr_ok;
        r_ctrl    <= n_ctrl;
        r_len     <= n_len;
        r_data    <= n_data;
        r_csum_ok <= n_csum_ok;
    end

endmodule
`default_nettype wire

### sv/mfrd_queue.sv
// Short request queue between the parser and the decoder.
// Register array with read/write pointers. Depends on mfrd_pkg.
`default_nettype none
module mfrd_queue #(
    parameter int DEPTH = mfrd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mfrd_pkg::t_rec i_rec,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output mfrd_pkg::t_rec      o_rec
);
    import mfrd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule
`default_nettype wire

### sv/mfrd_back.sv
// Back end: BCD reading decode in two stages and the result register.
// Depends on mfrd_pkg.
`default_nettype none
module mfrd_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire mfrd_pkg::t_rec              i_q_rec,
    output logic                             o_q_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [1:0]                       o_status,
    output logic [7:0]                       o_control_code,
    output logic [8:0]                       o_frame_length,
    output logic [mfrd_pkg::READ_W-1:0]      o_reading_hundredths
);
    import mfrd_pkg::*;

    logic        r_s1_valid;
    t_status     r_s1_status;
    logic [7:0]  r_s1_ctrl;
    logic [8:0]  r_s1_len;
    logic [14:0] r_s1_p0, r_s1_p1;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [7:0]        r_out_ctrl;
    logic [8:0]        r_out_len;
    logic [READ_W-1:0] r_out_reading;

    logic        adv_out, s1_take;
    logic [7:0]  v2, v3, v4, v5;
    logic [14:0] n_p0, n_p1;
    logic        rd_ok;
    logic [READ_W-1:0] n_reading;

    assign adv_out = !r_out_valid || i_ready;
    assign s1_take = !r_s1_valid || adv_out;
    assign o_q_pop = i_q_valid && s1_take;

    // non-reading frames decode to zero
    assign rd_ok = (i_q_rec.status == ST_READING);
    assign v2    = bcd_byte(i_q_rec.reading_raw[7:0]   - DATA_OFFSET);
    assign v3    = bcd_byte(i_q_rec.reading_raw[15:8]  - DATA_OFFSET);
    assign v4    = bcd_byte(i_q_rec.reading_raw[23:16] - DATA_OFFSET);
    assign v5    = bcd_byte(i_q_rec.reading_raw[31:24] - DATA_OFFSET);
    assign n_p0  = rd_ok ? (15'(v3) * 15'd100 + 15'(v2)) : 15'd0;
    assign n_p1  = rd_ok ? (15'(v5) * 15'd100 + 15'(v4)) : 15'd0;
    assign n_reading = READ_W'(r_s1_p1) * READ_W'(10000) + READ_W'(r_s1_p0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_take) begin
                r_s1_valid <= i_q_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_status <= i_q_rec.status;
            r_s1_ctrl   <= i_q_rec.control;
            r_s1_len    <= i_q_rec.frame_len;
            r_s1_p0     <= n_p0;
            r_s1_p1     <= n_p1;
        end
        if (adv_out && r_s1_valid) begin
            r_out_status  <= r_s1_status;
            r_out_ctrl    <= r_s1_ctrl;
            r_out_len     <= r_s1_len;
            r_out_reading <= n_reading;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_control_code       = r_out_ctrl;
    assign o_frame_length       = r_out_len;
    assign o_reading_hundredths = r_out_reading;

endmodule
`default_nettype wire

### sv/mfrd_checker.sv
// Port-level checker for the meter frame receiver, bound to the top level.
// Depends on mfrd_pkg and meter_frame_receiver_decoder_top_assert.svh.
`default_nettype none
`include "meter_frame_receiver_decoder_top_assert.svh"
module mfrd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic [1:0]                  o_status,
    input wire logic [7:0]                  o_control_code,
    input wire logic [8:0]                  o_frame_length,
    input wire logic [mfrd_pkg::READ_W-1:0] o_reading_hundredths
);
    import mfrd_pkg::*;

    `MFRD_ASSERT_ALWAYS(a_rst_idle, !i_rst_n, !o_valid, "result valid after reset")

    `MFRD_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_control_code) && $stable(o_frame_length) && $stable(o_reading_hundredths), "stalled result changed")

    `MFRD_ASSERT_NOW(a_addr_err_zero, o_valid && o_status == ST_ADDR_ERR, o_control_code == 8'd0 && o_frame_length == 9'd0, "address error with nonzero fields")

    `MFRD_ASSERT_NOW(a_no_read_zero, o_valid && o_status != ST_READING, o_reading_hundredths == '0, "reading without reading status")

    `MFRD_ASSERT_NOW(a_frame_len_min, o_valid && (o_status == ST_OTHER || o_status == ST_READING || o_status == ST_CSUM_ERR), o_frame_length >= FRAME_EXTRA, "frame length below header size")

endmodule

bind meter_frame_receiver_decoder_top mfrd_checker u_mfrd_checker (.*);
`default_nettype wire
